### hw/rtl/bdrm_pkg.sv
`timescale 1ns / 1ps
package bdrm_pkg;

	// sizing
	localparam int CHANNELS   = 4;
	localparam int WINDOW     = 10;
	localparam int CH_W       = 2;
	localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int LEVEL_W    = 14;
	localparam int TIME_W     = 32;
	localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FILL_W     = $clog2(WINDOW + 1);
	localparam int DEPTH      = CHANNELS * WINDOW;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int ENTRY_W    = LEVEL_W + TIME_W;

	// arithmetic
	localparam int LEVEL_MAX  = 10000;
	localparam int RATE_SCALE = 10000;
	localparam int TIME_SCALE = 10;
	localparam int DIV_W      = 27;
	localparam int QT_W       = 17;
	localparam int BRIEF_SHIFT = DIV_W - QT_W;
	localparam int CNT_W      = $clog2(DIV_W + 1);
	localparam int RATE_W     = 28;

	// configuration registers
	localparam int WARN_W     = 27;
	localparam int CRIT_W     = 14;
	localparam int CFG_W      = 27;
	localparam int CFG_IDX_W  = 1;
	localparam logic [CFG_IDX_W-1:0] REG_WARN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CRIT = 1'd1;
	localparam logic [WARN_W-1:0] WARN_RESET = 27'd1500;
	localparam logic [CRIT_W-1:0] CRIT_RESET = 14'd2000;

	typedef struct packed {
		logic start;
		logic brief;	// 17-bit dividend, 17 steps
	} div_req_t;

endpackage

### hw/rtl/battery_drain_rate_monitor_core.sv
`timescale 1ns / 1ps
// Channel  | Handshake                  | Beat
// ---------+----------------------------+--------------------------------------------
// sample   | sample_valid/sample_ready  | channel, battery_level, sample_time
// report   | report_valid/report_ready  | out_channel, loss_rate, warning,
//          |                            | critical_valid, crit_secs,
//          |                            | depletion_valid, empty_secs
// config   | cfg_we                     | cfg_index, cfg_data
//
// A sample holds the block from accept to next accept: one shared radix-2 divider
// runs the rate division (27 steps) and then, for a positive rate, the two time
// divisions (17 steps each) in turn, each only if the level is above its threshold.
// Samples without a rate skip the divider.
// sample_ready is high only in idle.
// A finished report waits in the output register; the next sample is taken meanwhile
// and only its own report waits for report_ready.
// arst_n clears the sequencer, fill counts, write slots and config; window RAM is not.
module battery_drain_rate_monitor_core import bdrm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     sample_valid,
	output logic                     sample_ready,
	input  logic [CH_W-1:0]          channel,
	input  logic [LEVEL_W-1:0]       battery_level,
	input  logic [TIME_W-1:0]        sample_time,
	output logic                     report_valid,
	input  logic                     report_ready,
	output logic [CH_W-1:0]          out_channel,
	output logic signed [RATE_W-1:0] loss_rate,
	output logic                     warning,
	output logic                     critical_valid,
	output logic [QT_W-1:0]          crit_secs,
	output logic                     depletion_valid,
	output logic [QT_W-1:0]          empty_secs
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_CALC = 3'd2;
	localparam logic [2:0] ST_DIVR = 3'd3;
	localparam logic [2:0] ST_DIVC = 3'd4;
	localparam logic [2:0] ST_DIVD = 3'd5;
	localparam logic [2:0] ST_EMIT = 3'd6;

	logic [2:0]          state_q;
	logic [WARN_W-1:0]   warn_q;
	logic [CRIT_W-1:0]   crit_q;
	logic [FILL_W-1:0]   fill_q [CHANNELS];
	logic [SLOT_W-1:0]   slot_q [CHANNELS];

	// current item
	logic [CH_W-1:0]     ch_q;
	logic [LEVEL_W-1:0]  lvl_q;
	logic [TIME_W-1:0]   t_q;
	logic [ADDR_W-1:0]   wr_addr_q;
	logic [ADDR_W-1:0]   rd_addr_q;
	logic                two_q;
	logic                neg_q;

	// result being built
	logic [RATE_W-1:0]   rate_q;
	logic                warn_flag_q;
	logic                cval_q;
	logic [QT_W-1:0]     ttc_q;
	logic                dval_q;
	logic [QT_W-1:0]     ttd_q;

	// output register
	logic                rep_valid_q;
	logic [CH_W-1:0]     rep_ch_q;
	logic [RATE_W-1:0]   rep_rate_q;
	logic                rep_warn_q;
	logic                rep_cval_q;
	logic [QT_W-1:0]     rep_ttc_q;
	logic                rep_dval_q;
	logic [QT_W-1:0]     rep_ttd_q;

	// divider interface
	div_req_t            div_req_d;
	div_req_t            div_req_q;
	logic [DIV_W-1:0]    div_num_q;
	logic [TIME_W-1:0]   div_den_q;
	logic                div_done;
	logic [DIV_W-1:0]    div_quo;

	// window RAM
	logic                ram_we;
	logic                ram_re;
	logic [ENTRY_W-1:0]  ram_wdata;
	logic [ENTRY_W-1:0]  ram_rdata;

	// accept-time slot arithmetic
	logic                accept;
	logic                ch_ok;
	logic [CH_IDX_W-1:0] ci;
	logic [LEVEL_W-1:0]  lvl_sat;
	logic [FILL_W-1:0]   fill_old;
	logic [FILL_W-1:0]   fill_new;
	logic [SLOT_W-1:0]   slot_old;
	logic [SLOT_W-1:0]   slot_new;
	logic [SLOT_W:0]     old_sum;
	logic [SLOT_W-1:0]   old_slot;
	logic [ADDR_W-1:0]   ch_base;

	// window arithmetic
	logic [LEVEL_W-1:0]  old_lvl;
	logic [TIME_W-1:0]   old_t;
	logic [LEVEL_W:0]    dl;
	logic [LEVEL_W-1:0]  dl_mag;
	logic                dl_neg;
	logic                t_ok;

	// after rate division
	logic [RATE_W-1:0]   q_ext;
	logic                rate_pos;
	logic                crit_ok;
	logic                emit_go;
	logic [DIV_W-1:0]    crit_num;
	logic [DIV_W-1:0]    dep_num;

	assign sample_ready = (state_q == ST_IDLE);
	assign accept       = sample_valid && sample_ready;
	assign ch_ok        = int'(channel) < CHANNELS;
	assign ci           = channel[CH_IDX_W-1:0];
	assign lvl_sat      = (battery_level > LEVEL_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX)
		: battery_level;
	assign fill_old     = fill_q[ci];
	assign fill_new     = (fill_old < FILL_W'(WINDOW)) ? fill_old + 1'b1 : FILL_W'(WINDOW);
	assign slot_old     = slot_q[ci];
	assign slot_new     = (slot_old == SLOT_W'(WINDOW - 1)) ? '0 : slot_old + 1'b1;
	assign old_sum      = (SLOT_W + 1)'(slot_new) + (SLOT_W + 1)'(WINDOW)
		- (SLOT_W + 1)'(fill_new);
	assign old_slot     = (old_sum >= (SLOT_W + 1)'(WINDOW))
		? SLOT_W'(old_sum - (SLOT_W + 1)'(WINDOW)) : SLOT_W'(old_sum);
	assign ch_base      = ADDR_W'(ci) * ADDR_W'(WINDOW);

	assign old_lvl  = ram_rdata[ENTRY_W-1:TIME_W];
	assign old_t    = ram_rdata[TIME_W-1:0];
	assign dl       = {1'b0, old_lvl} - {1'b0, lvl_q};
	assign dl_neg   = dl[LEVEL_W];
	assign dl_mag   = dl_neg ? LEVEL_W'(-dl) : dl[LEVEL_W-1:0];
	assign t_ok     = t_q > old_t;

	assign q_ext    = RATE_W'(div_quo);
	assign rate_pos = !neg_q && (div_quo != '0);
	assign crit_ok  = lvl_q > crit_q;
	assign crit_num = DIV_W'(lvl_q - crit_q) * DIV_W'(TIME_SCALE);
	assign dep_num  = DIV_W'(lvl_q) * DIV_W'(TIME_SCALE);
	assign emit_go  = !rep_valid_q || report_ready;

	assign ram_we    = (state_q == ST_READ);
	assign ram_re    = (state_q == ST_READ);
	assign ram_wdata = {lvl_q, t_q};

	bdrm_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_window (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_addr_q),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(rd_addr_q),
		.rdata(ram_rdata)
	);

	bdrm_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (div_req_q),
		.dividend(div_num_q),
		.divisor (div_den_q),
		.done    (div_done),
		.quotient(div_quo)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warn_q <= WARN_RESET;
			crit_q <= CRIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WARN: warn_q <= cfg_data[WARN_W-1:0];
				REG_CRIT: crit_q <= cfg_data[CRIT_W-1:0];
				default: ;
			endcase
		end
	end

	// divider launches
	always_comb begin
		div_req_d = '{start: 1'b0, brief: 1'b0};
		case (state_q)
			ST_CALC: begin
				if (two_q && t_ok) begin
					div_req_d = '{start: 1'b1, brief: 1'b0};
				end
			end
			ST_DIVR: begin
				if (div_done && rate_pos && (crit_ok || (lvl_q != '0))) begin
					div_req_d = '{start: 1'b1, brief: 1'b1};
				end
			end
			ST_DIVC: begin
				if (div_done && dval_q) begin
					div_req_d = '{start: 1'b1, brief: 1'b1};
				end
			end
			default: ;
		endcase
	end

	// sequencer and per-channel ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_req_q   <= '0;
			rep_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				fill_q[i] <= '0;
				slot_q[i] <= '0;
			end
		end else begin
			div_req_q   <= div_req_d;
			rep_valid_q <= ((state_q == ST_EMIT) && emit_go) || (rep_valid_q && !report_ready);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (ch_ok) begin
							fill_q[ci] <= fill_new;
							slot_q[ci] <= slot_new;
							state_q    <= ST_READ;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_READ: state_q <= ST_CALC;
				ST_CALC: begin
					if (two_q && t_ok) begin
						state_q <= ST_DIVR;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_DIVR: begin
					if (div_done) begin
						if (rate_pos && crit_ok) begin
							state_q <= ST_DIVC;
						end else if (rate_pos && (lvl_q != '0)) begin
							state_q <= ST_DIVD;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_DIVC: begin
					if (div_done) begin
						if (dval_q) begin
							state_q <= ST_DIVD;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_DIVD: begin
					if (div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item payload and result build-up
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ch_q        <= channel;
					lvl_q       <= lvl_sat;
					t_q         <= sample_time;
					wr_addr_q   <= ch_base + ADDR_W'(slot_old);
					rd_addr_q   <= ch_base + ADDR_W'(old_slot);
					two_q       <= fill_new >= FILL_W'(2);
					rate_q      <= '0;
					warn_flag_q <= 1'b0;
					cval_q      <= 1'b0;
					ttc_q       <= '0;
					dval_q      <= 1'b0;
					ttd_q       <= '0;
				end
			end
			ST_CALC: begin
				neg_q     <= dl_neg;
				div_num_q <= DIV_W'(dl_mag) * DIV_W'(RATE_SCALE);
				div_den_q <= t_q - old_t;
			end
			ST_DIVR: begin
				if (div_done) begin
					rate_q      <= neg_q ? -q_ext : q_ext;
					// threshold is non-negative, so only a positive rate can exceed it
					warn_flag_q <= rate_pos && (div_quo > DIV_W'(warn_q));
					cval_q      <= rate_pos && crit_ok;
					dval_q      <= rate_pos && (lvl_q != '0);
					div_den_q   <= TIME_W'(div_quo);
					div_num_q   <= crit_ok ? crit_num : dep_num;
				end
			end
			ST_DIVC: begin
				if (div_done) begin
					ttc_q     <= div_quo[QT_W-1:0];
					div_num_q <= dep_num;
				end
			end
			ST_DIVD: begin
				if (div_done) begin
					ttd_q <= div_quo[QT_W-1:0];
				end
			end
			ST_EMIT: begin
				if (emit_go) begin
					rep_ch_q   <= ch_q;
					rep_rate_q <= rate_q;
					rep_warn_q <= warn_flag_q;
					rep_cval_q <= cval_q;
					rep_ttc_q  <= ttc_q;
					rep_dval_q <= dval_q;
					rep_ttd_q  <= ttd_q;
				end
			end
			default: ;
		endcase
	end

	assign report_valid    = rep_valid_q;
	assign out_channel     = rep_ch_q;
	assign loss_rate       = $signed(rep_rate_q);
	assign warning         = rep_warn_q;
	assign critical_valid  = rep_cval_q;
	assign crit_secs       = rep_ttc_q;
	assign depletion_valid = rep_dval_q;
	assign empty_secs      = rep_ttd_q;

endmodule

### hw/rtl/bdrm_ram.sv
`timescale 1ns / 1ps
module bdrm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/bdrm_div.sv
`timescale 1ns / 1ps
module bdrm_div import bdrm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  div_req_t          req,
	input  logic [DIV_W-1:0]  dividend,
	input  logic [TIME_W-1:0] divisor,
	output logic              done,
	output logic [DIV_W-1:0]  quotient
);

	// restoring divider, one quotient bit per cycle
	logic [TIME_W-1:0] rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [TIME_W-1:0] den_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [TIME_W:0]   trial;
	logic [TIME_W:0]   diff;
	logic              fits;
	logic [TIME_W-1:0] rem_next;

	assign trial    = {rem_q, quo_q[DIV_W-1]};
	assign diff     = trial - {1'b0, den_q};
	assign fits     = trial >= {1'b0, den_q};
	assign rem_next = fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.brief ? CNT_W'(QT_W) : CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= divisor;
			// short operands are left-aligned so their top bit comes out first
			quo_q <= req.brief ? (dividend << BRIEF_SHIFT) : dividend;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### dv/battery_drain_rate_monitor_core_tb.sv
`timescale 1ns / 1ps
module battery_drain_rate_monitor_core_tb;
	import bdrm_pkg::*;

	typedef struct {
		logic [CH_W-1:0]    ch;
		logic [LEVEL_W-1:0] level;
		logic [TIME_W-1:0]  stamp;
	} sample_beat_t;

	typedef struct {
		logic [CH_W-1:0]          out_channel;
		logic signed [RATE_W-1:0] loss_rate;
		logic                     warning;
		logic                     critical_valid;
		logic [QT_W-1:0]          crit_secs;
		logic                     depletion_valid;
		logic [QT_W-1:0]          empty_secs;
	} drain_report_t;

	localparam int RANDOM_PER_PHASE = 410;
	localparam int SETTLE_CYCLES    = 80;
	localparam int LONG_HOLD        = 600;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = REG_WARN;
	logic [CFG_W-1:0]         cfg_data = '0;
	logic                     sample_valid = 1'b0;
	logic                     sample_ready;
	logic [CH_W-1:0]          channel = '0;
	logic [LEVEL_W-1:0]       battery_level = '0;
	logic [TIME_W-1:0]        sample_time = '0;
	logic                     report_valid;
	logic                     report_ready = 1'b0;
	logic [CH_W-1:0]          out_channel;
	logic signed [RATE_W-1:0] loss_rate;
	logic                     warning;
	logic                     critical_valid;
	logic [QT_W-1:0]          crit_secs;
	logic                     depletion_valid;
	logic [QT_W-1:0]          empty_secs;

	battery_drain_rate_monitor_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.sample_valid(sample_valid), .sample_ready(sample_ready),
		.channel(channel), .battery_level(battery_level), .sample_time(sample_time),
		.report_valid(report_valid), .report_ready(report_ready),
		.out_channel(out_channel), .loss_rate(loss_rate), .warning(warning),
		.critical_valid(critical_valid), .crit_secs(crit_secs),
		.depletion_valid(depletion_valid), .empty_secs(empty_secs)
	);

	always #5 clk = ~clk;

	// shadow of the block's window state and registers
	logic [LEVEL_W-1:0] win_level [CHANNELS][WINDOW];
	logic [TIME_W-1:0]  win_stamp [CHANNELS][WINDOW];
	int                 win_fill [CHANNELS];
	int                 win_slot [CHANNELS];
	logic [WARN_W-1:0]  warn_cfg = WARN_RESET;
	logic [CRIT_W-1:0]  crit_cfg = CRIT_RESET;

	sample_beat_t  pending_samples [$];
	drain_report_t expected_reports [$];

	// stimulus trackers for well-formed per-channel sequences
	int          gen_level [CHANNELS];
	logic [31:0] gen_stamp [CHANNELS];

	int  err_count = 0;
	int  reports_checked = 0;
	int  positive_rates = 0;
	int  warnings_seen = 0;
	int  settings_used = 1;
	bit  sample_fired = 1'b0;
	bit  calm = 1'b0;
	bit  hold_start = 1'b0;
	int  hold_left = 0;
	int  stall_left = 0;
	int  gap_left = 0;
	sample_beat_t beat;

	initial begin
		for (int c = 0; c < CHANNELS; c++) begin
			win_fill[c] = 0;
			win_slot[c] = 0;
			gen_level[c] = LEVEL_MAX;
			gen_stamp[c] = $urandom();
		end
	end

	function automatic drain_report_t predict_drain_report(sample_beat_t s);
		drain_report_t r;
		int chi, lvl, ws, fill, oldest, crit_i;
		longint dt, dl, rate, q;
		r = '{default: '0};
		r.out_channel = s.ch;
		chi = s.ch;
		lvl = (s.level > LEVEL_MAX) ? LEVEL_MAX : s.level;
		crit_i = crit_cfg;
		rate = 0;
		if (chi < CHANNELS) begin
			ws = win_slot[chi];
			win_level[chi][ws] = lvl[LEVEL_W-1:0];
			win_stamp[chi][ws] = s.stamp;
			ws = (ws + 1) % WINDOW;
			win_slot[chi] = ws;
			fill = win_fill[chi];
			if (fill < WINDOW)
				fill++;
			win_fill[chi] = fill;
			if (fill >= 2) begin
				oldest = (ws + WINDOW - fill) % WINDOW;
				dt = longint'(s.stamp) - longint'(win_stamp[chi][oldest]);
				dl = longint'(win_level[chi][oldest]) - longint'(lvl);
				if (dt > 0)
					rate = dl * RATE_SCALE / dt;
			end
			r.warning = (rate > longint'(warn_cfg));
			if (rate > 0) begin
				positive_rates++;
				if (lvl > crit_i) begin
					r.critical_valid = 1'b1;
					q = longint'(lvl - crit_i) * TIME_SCALE / rate;
					r.crit_secs = q[QT_W-1:0];
				end
				if (lvl > 0) begin
					r.depletion_valid = 1'b1;
					q = longint'(lvl) * TIME_SCALE / rate;
					r.empty_secs = q[QT_W-1:0];
				end
			end
		end
		r.loss_rate = rate[RATE_W-1:0];
		if (r.warning)
			warnings_seen++;
		return r;
	endfunction

	// mostly plausible telemetry, with some noise and broken ordering mixed in
	function automatic sample_beat_t random_sample();
		sample_beat_t s;
		int c, mode;
		c = $urandom_range(0, CHANNELS - 1);
		mode = $urandom_range(0, 99);
		s.ch = c[CH_W-1:0];
		if (mode < 82) begin
			case ($urandom_range(0, 3))
				0: gen_stamp[c] += $urandom_range(0, 3);
				1: gen_stamp[c] += $urandom_range(1, 2000);
				2: gen_stamp[c] += $urandom_range(1000, 100000);
				default: gen_stamp[c] += $urandom_range(10, 400);
			endcase
			if ($urandom_range(0, 49) == 0 || gen_level[c] == 0)
				gen_level[c] = $urandom_range(5000, 10000);
			else if ($urandom_range(0, 19) == 0)
				gen_level[c] += $urandom_range(0, 60);
			else
				gen_level[c] -= $urandom_range(0, 40);
			if (gen_level[c] < 0)
				gen_level[c] = 0;
			if (gen_level[c] > 16383)
				gen_level[c] = 16383;
			s.level = gen_level[c][LEVEL_W-1:0];
			s.stamp = gen_stamp[c];
		end else if (mode < 92) begin
			s.level = LEVEL_W'($urandom_range(0, 16383));
			s.stamp = gen_stamp[c] - $urandom_range(0, 5000);
		end else begin
			s.level = LEVEL_W'($urandom_range(0, 16383));
			s.stamp = $urandom();
			gen_stamp[c] = s.stamp;
		end
		return s;
	endfunction

	task automatic push_sample(int c, int lvl, logic [31:0] stamp);
		sample_beat_t s;
		s.ch = c[CH_W-1:0];
		s.level = lvl[LEVEL_W-1:0];
		s.stamp = stamp;
		pending_samples.insert(pending_samples.size(), s);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == REG_WARN)
			warn_cfg = value[WARN_W-1:0];
		else
			crit_cfg = value[CRIT_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (!(pending_samples.size() == 0 && !sample_valid &&
				expected_reports.size() == 0)) begin
			@(posedge clk);
			#1;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic add_random(int count);
		repeat (count) pending_samples.insert(pending_samples.size(), random_sample());
	endtask

	// sample driver
	always @(negedge clk) begin
		if (!(sample_valid && !sample_fired)) begin
			if (gap_left > 0) begin
				gap_left--;
				sample_valid <= 1'b0;
			end else if (pending_samples.size() == 0) begin
				sample_valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				gap_left = $urandom_range(0, 17);
				sample_valid <= 1'b0;
			end else begin
				beat = pending_samples[0];
				pending_samples.delete(0);
				channel <= beat.ch;
				battery_level <= beat.level;
				sample_time <= beat.stamp;
				sample_valid <= 1'b1;
			end
		end
		sample_fired = 1'b0;
	end

	// report sink with random stalls and one long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			report_ready <= 1'b0;
		end else if (hold_start) begin
			hold_start = 1'b0;
			hold_left = LONG_HOLD - 1;
			report_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			report_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 17);
			report_ready <= 1'b0;
		end else begin
			report_ready <= 1'b1;
		end
	end

	// beat monitor: check reports first, then record accepted samples
	always @(posedge clk) begin
		drain_report_t exp_r;
		if (arst_n && report_valid && report_ready) begin
			if (expected_reports.size() == 0) begin
				$error("report beat with no sample pending, out_channel %0d", out_channel);
				err_count++;
			end else begin
				exp_r = expected_reports[0];
				expected_reports.delete(0);
				reports_checked++;
				if (out_channel !== exp_r.out_channel) begin
					$error("out_channel: expected %0d, actual %0d",
						exp_r.out_channel, out_channel);
					err_count++;
				end
				if (loss_rate !== exp_r.loss_rate) begin
					$error("loss_rate: expected %0d, actual %0d",
						exp_r.loss_rate, loss_rate);
					err_count++;
				end
				if (warning !== exp_r.warning) begin
					$error("warning: expected %0d, actual %0d", exp_r.warning, warning);
					err_count++;
				end
				if (critical_valid !== exp_r.critical_valid) begin
					$error("critical_valid: expected %0d, actual %0d",
						exp_r.critical_valid, critical_valid);
					err_count++;
				end
				if (crit_secs !== exp_r.crit_secs) begin
					$error("crit_secs: expected %0d, actual %0d",
						exp_r.crit_secs, crit_secs);
					err_count++;
				end
				if (depletion_valid !== exp_r.depletion_valid) begin
					$error("depletion_valid: expected %0d, actual %0d",
						exp_r.depletion_valid, depletion_valid);
					err_count++;
				end
				if (empty_secs !== exp_r.empty_secs) begin
					$error("empty_secs: expected %0d, actual %0d",
						exp_r.empty_secs, empty_secs);
					err_count++;
				end
			end
		end
		if (arst_n && sample_valid && sample_ready) begin
			sample_fired = 1'b1;
			expected_reports.insert(expected_reports.size(), predict_drain_report(beat));
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed, reset thresholds
		push_sample(0, 16383, 32'd0);            // lone sample, saturated level
		push_sample(0, 10000, 32'd0);            // no time advance
		push_sample(0, 9000, 32'd1000);          // positive rate above warning
		push_sample(1, 10000, 32'd5000);
		push_sample(1, 0, 32'd5001);             // full-scale rate, empty battery
		push_sample(1, 5000, 32'd4000);          // time went backwards
		push_sample(2, 100, 32'd0);
		push_sample(2, 99, 32'd20000);           // rate truncates to zero
		push_sample(2, 200, 32'd30000);          // charging, negative rate
		push_sample(2, 50, 32'hFFFF_FFFF);
		push_sample(3, 3000, 32'hFFFF_FED8);
		push_sample(3, 1500, 32'hFFFF_FFFF);     // below critical level
		push_sample(3, 8191, 32'h8000_0000);
		add_random(RANDOM_PER_PHASE);
		wait_drained();

		write_reg(REG_WARN, '0);
		write_reg(REG_CRIT, '0);
		settings_used++;
		// slowest drain the block can resolve: 1 unit over a full window
		repeat (WINDOW) push_sample(1, 10000, 32'd70000);
		push_sample(1, 9999, 32'd80000);
		add_random(RANDOM_PER_PHASE);
		wait_drained();

		write_reg(REG_WARN, 27'h7FF_FFFF);
		write_reg(REG_CRIT, 27'd10000);
		settings_used++;
		add_random(RANDOM_PER_PHASE);
		@(posedge clk);
		#1;
		hold_start = 1'b1;
		wait_drained();

		write_reg(REG_WARN, CFG_W'($urandom_range(0, 200000)));
		write_reg(REG_CRIT, 27'h3FFF);
		settings_used++;
		add_random(RANDOM_PER_PHASE / 2);
		wait_drained();

		write_reg(REG_WARN, CFG_W'($urandom_range(500, 50000)));
		write_reg(REG_CRIT, CFG_W'($urandom_range(0, 10000)));
		settings_used++;
		calm = 1'b1;
		add_random(RANDOM_PER_PHASE / 2);
		wait_drained();

		$display("Run covered %0d reports across %0d register settings.",
			reports_checked, settings_used);
		$display("%0d reports had a positive drain rate, %0d raised the warning.",
			positive_rates, warnings_seen);
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#(64'd15_000_000);
		$display("TB_ERROR");
		$finish;
	end

endmodule
